// File: src/hvni_pkg.sv
// Package for the hashed value-noise interpolator.
// Holds default parameters, hash constants, interpolation mode codes and register map.
// No dependencies.
package hvni_pkg;

  localparam int TABLE_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int HASH_STAGES = 4;
  localparam int WEIGHT_STAGES = 4;
  localparam int MAC_STAGES = 3;
  localparam int PIPE_STAGES = 1 + HASH_STAGES + MAC_STAGES;

  localparam logic [31:0] HASH_MUL  = 32'd60493;
  localparam logic [31:0] HASH_ADD1 = 32'd19990303;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
  localparam int HASH_XOR_SHIFT = 13;

  typedef enum logic [1:0] {
    MODE_NEAREST = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_CUBIC   = 2'd2
  } interp_mode_t;

  localparam logic [1:0] MODE_RESET = MODE_CUBIC;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_INTERP_MODE = 1'b0;

endpackage

// File: src/hvni_hash.sv
// Four-stage pipelined lattice hash: index to signed fixed-point lattice value.
// Uses hvni_pkg for the hash constants.
module hvni_hash #(
  parameter int TABLE_BITS = hvni_pkg::TABLE_BITS_DEF,
  parameter int FRAC_BITS  = hvni_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [hvni_pkg::HASH_STAGES-1:0]     stage_en,
  input  logic [TABLE_BITS-1:0]                idx,
  output logic signed [FRAC_BITS+1:0]          lattice
);

  localparam int LW = FRAC_BITS + 2;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [LW-1:0] ONE_L = LW'(1) << FRAC_BITS;
  localparam logic [31:0] CEIL_ADD = (32'd1 << SH) - 32'd1;

  logic [TABLE_BITS-1:0] m;
  logic [31:0] m32;
  logic [31:0] sq_nxt, t_nxt, p_nxt;
  logic [30:0] nn;
  logic [31:0] ceil_sum, ceil_q;
  logic [LW-1:0] lat_nxt;

  logic [31:0] m1_r, sq1_r, m2_r, t2_r, p3_r;
  logic signed [LW-1:0] lat4_r;

  always_comb begin
    m        = idx ^ (idx >> hvni_pkg::HASH_XOR_SHIFT);
    m32      = 32'(m);
    sq_nxt   = m32 * m32;
    t_nxt    = sq1_r * hvni_pkg::HASH_MUL + hvni_pkg::HASH_ADD1;
    p_nxt    = t2_r * m2_r;
    nn       = p3_r[30:0] + hvni_pkg::HASH_ADD2[30:0];
    ceil_sum = {1'b0, nn} + CEIL_ADD;
    ceil_q   = ceil_sum >> SH;
    lat_nxt  = ONE_L - ceil_q[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      m1_r  <= m32;
      sq1_r <= sq_nxt;
    end
    if (stage_en[1]) begin
      m2_r <= m1_r;
      t2_r <= t_nxt;
    end
    if (stage_en[2]) begin
      p3_r <= p_nxt;
    end
    if (stage_en[3]) begin
      lat4_r <= signed'(lat_nxt);
    end
  end

  assign lattice = lat4_r;

endmodule

// File: src/hvni_weight.sv
// Four-stage pipeline that turns the phase fraction into four interpolation weights.
// Uses hvni_pkg for the mode codes.
module hvni_weight #(
  parameter int FRAC_BITS = hvni_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [hvni_pkg::WEIGHT_STAGES-1:0]   stage_en,
  input  logic [FRAC_BITS-1:0]                 frac,
  input  logic [1:0]                           mode,
  output logic signed [FRAC_BITS+3:0]          weight [4]
);

  localparam int WW = FRAC_BITS + 4;
  localparam int PW = 2 * FRAC_BITS;
  localparam logic signed [WW-1:0] TWO_ONE = WW'(1) <<< (FRAC_BITS + 1);

  logic [PW-1:0] ff, fx;
  logic signed [WW-1:0] sx2, sx3, sf;
  logic signed [WW-1:0] w_nxt [4];

  logic [FRAC_BITS-1:0] x2_1_r, f1_r, x2_2_r, x3_2_r, f2_r;
  logic [1:0] mode1_r, mode2_r;
  logic signed [WW-1:0] w3_r [4];
  logic signed [WW-1:0] w4_r [4];

  always_comb begin
    ff  = PW'(frac) * PW'(frac);
    fx  = PW'(x2_1_r) * PW'(f1_r);
    sx2 = signed'(WW'(x2_2_r));
    sx3 = signed'(WW'(x3_2_r));
    sf  = signed'(WW'(f2_r));
    unique case (mode2_r)
      hvni_pkg::MODE_NEAREST: begin
        w_nxt[0] = '0;
        w_nxt[1] = TWO_ONE;
        w_nxt[2] = '0;
        w_nxt[3] = '0;
      end
      hvni_pkg::MODE_LINEAR: begin
        w_nxt[0] = '0;
        w_nxt[1] = TWO_ONE - (sf <<< 1);
        w_nxt[2] = sf <<< 1;
        w_nxt[3] = '0;
      end
      default: begin
        w_nxt[0] = (sx2 <<< 1) - sx3 - sf;
        w_nxt[1] = (sx3 <<< 1) + sx3 - (sx2 <<< 2) - sx2 + TWO_ONE;
        w_nxt[2] = (sx2 <<< 2) + sf - (sx3 <<< 1) - sx3;
        w_nxt[3] = sx3 - sx2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x2_1_r  <= ff[PW-1:FRAC_BITS];
      f1_r    <= frac;
      mode1_r <= mode;
    end
    if (stage_en[1]) begin
      x3_2_r  <= fx[PW-1:FRAC_BITS];
      x2_2_r  <= x2_1_r;
      f2_r    <= f1_r;
      mode2_r <= mode1_r;
    end
    for (int k = 0; k < 4; k++) begin
      if (stage_en[2]) begin
        w3_r[k] <= w_nxt[k];
      end
      if (stage_en[3]) begin
        w4_r[k] <= w3_r[k];
      end
    end
  end

  assign weight = w4_r;

endmodule

// File: src/hvni_mac.sv
// Three-stage multiply-accumulate: four weighted lattice values, summed and scaled down.
// Uses hvni_pkg for the stage count.
module hvni_mac #(
  parameter int FRAC_BITS = hvni_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [hvni_pkg::MAC_STAGES-1:0]      stage_en,
  input  logic signed [FRAC_BITS+1:0]          lattice [4],
  input  logic signed [FRAC_BITS+3:0]          weight [4],
  output logic signed [FRAC_BITS+1:0]          noise_value
);

  localparam int LW = FRAC_BITS + 2;
  localparam int WW = FRAC_BITS + 4;
  localparam int PW = LW + WW;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_r [4];
  logic signed [SW-1:0] sum01_r, sum23_r;
  logic signed [SW-1:0] total, scaled;
  logic signed [LW-1:0] out_r;

  always_comb begin
    total  = sum01_r + sum23_r;
    scaled = total >>> (FRAC_BITS + 1);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PW'(lattice[k]) * PW'(weight[k]);
      end
    end
    if (stage_en[1]) begin
      sum01_r <= SW'(prod_r[0]) + SW'(prod_r[1]);
      sum23_r <= SW'(prod_r[2]) + SW'(prod_r[3]);
    end
    if (stage_en[2]) begin
      out_r <= scaled[LW-1:0];
    end
  end

  assign noise_value = out_r;

endmodule

// File: src/hashed_value_noise_interpolator_top.sv
// Top level of the hashed value-noise interpolator: register port, index stage and pipeline control.
// Depends on hvni_pkg, hvni_hash, hvni_weight and hvni_mac.
//
// The block accepts one phase per clock cycle while in_ready is high. Each transaction passes
// through eight register stages (one index stage, four hash stages and three multiply-accumulate
// stages) before its noise sample is offered. All four lattice values are hashed in parallel by
// four pipelined multiplier chains, so the throughput is one transaction per cycle whatever the
// interpolation mode when the output is not stalled. Each pipeline stage holds its own valid bit,
// so a stall at the output fills empty stages before the input stops.
// The interpolation mode register resets to cubic and should be written only while idle.
module hashed_value_noise_interpolator_top #(
  parameter int TABLE_BITS = hvni_pkg::TABLE_BITS_DEF,
  parameter int FRAC_BITS  = hvni_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hvni_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [hvni_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [hvni_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [TABLE_BITS+FRAC_BITS-1:0]      in_phase,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [FRAC_BITS+1:0]          out_noise_value
);

  localparam int PB = TABLE_BITS + FRAC_BITS;
  localparam int NS = hvni_pkg::PIPE_STAGES;
  localparam int HS = hvni_pkg::HASH_STAGES;
  localparam int LW = FRAC_BITS + 2;
  localparam int WW = FRAC_BITS + 4;
  localparam logic [PB:0] HALF = (PB + 1)'(1) << (FRAC_BITS - 1);

  logic [1:0] interp_mode_r;
  logic cfg_wr;

  logic [NS-1:0] valid_r;
  logic [NS:0] stage_en;

  logic [TABLE_BITS-1:0] idx_n, idx_rnd;
  logic [PB:0] rnd_sum;
  logic [TABLE_BITS-1:0] idx_nxt [4];
  logic [TABLE_BITS-1:0] idx_r [4];
  logic [FRAC_BITS-1:0] frac_r;
  logic [1:0] mode_r;

  logic signed [LW-1:0] lattice [4];
  logic signed [WW-1:0] weight [4];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_mode_r <= hvni_pkg::MODE_RESET;
    end else if (cfg_wr && (paddr[hvni_pkg::CFG_ADDR_W-1] == hvni_pkg::REG_IDX_INTERP_MODE)) begin
      interp_mode_r <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[hvni_pkg::CFG_ADDR_W-1] == hvni_pkg::REG_IDX_INTERP_MODE) begin
      prdata[1:0] = interp_mode_r;
    end
  end

  always_comb begin
    stage_en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_comb begin
    idx_n      = in_phase[PB-1:FRAC_BITS];
    rnd_sum    = (PB + 1)'(in_phase) + HALF;
    idx_rnd    = rnd_sum[PB-1:FRAC_BITS];
    idx_nxt[0] = idx_n - TABLE_BITS'(1);
    idx_nxt[1] = (interp_mode_r == hvni_pkg::MODE_NEAREST) ? idx_rnd : idx_n;
    idx_nxt[2] = idx_n + TABLE_BITS'(1);
    idx_nxt[3] = idx_n + TABLE_BITS'(2);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int k = 0; k < 4; k++) begin
        idx_r[k] <= idx_nxt[k];
      end
      frac_r <= in_phase[FRAC_BITS-1:0];
      mode_r <= interp_mode_r;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    hvni_hash #(
      .TABLE_BITS (TABLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_hash (
      .clk      (clk),
      .stage_en (stage_en[HS:1]),
      .idx      (idx_r[g]),
      .lattice  (lattice[g])
    );
  end

  hvni_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk      (clk),
    .stage_en (stage_en[HS:1]),
    .frac     (frac_r),
    .mode     (mode_r),
    .weight   (weight)
  );

  hvni_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk         (clk),
    .stage_en    (stage_en[NS-1:HS+1]),
    .lattice     (lattice),
    .weight      (weight),
    .noise_value (out_noise_value)
  );

endmodule

// File: src/hvni_checker.sv
// Port-level checker for the hashed value-noise interpolator, bound to the top level.
// Depends on hvni_pkg and hashed_value_noise_interpolator_top.
module hvni_checker #(
  parameter int TABLE_BITS = hvni_pkg::TABLE_BITS_DEF,
  parameter int FRAC_BITS  = hvni_pkg::FRAC_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [hvni_pkg::CFG_ADDR_W-1:0]      paddr,
  input logic [hvni_pkg::CFG_DATA_W-1:0]      pwdata,
  input logic [hvni_pkg::CFG_DATA_W-1:0]      prdata,
  input logic                                 pready,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [TABLE_BITS+FRAC_BITS-1:0]      in_phase,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [FRAC_BITS+1:0]          out_noise_value
);

  localparam int AT = hvni_pkg::CFG_ADDR_W - 1;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("Stalled result changed or dropped.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_phase))
    else $error("Waiting input transaction changed or dropped.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output is empty.");

  a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[AT] == hvni_pkg::REG_IDX_INTERP_MODE)
    |=> (paddr[AT] != hvni_pkg::REG_IDX_INTERP_MODE) || (prdata[1:0] == $past(pwdata[1:0])))
    else $error("Mode register readback does not match the written value.");

endmodule

bind hashed_value_noise_interpolator_top hvni_checker #(
  .TABLE_BITS (TABLE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_hvni_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_phase        (in_phase),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value)
);
